>>> rtl/core/rmp_pkg.sv
// package: widths, codes and helper functions of the move profiler
`default_nettype none
package rmp_pkg;

  localparam int ENC_W   = 32;
  localparam int DIST_W  = 16;
  localparam int DIR_W   = 3;
  localparam int SPEED_W = 7;
  localparam int RAMP_W  = 8;
  localparam int DRIVE_W = 8;
  localparam int ZONE_W  = 16;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 16;

  localparam logic [SPEED_W-1:0] SPEED_CAP_RST   = 7'd55;
  localparam logic [SPEED_W-1:0] SPEED_FLOOR_RST = 7'd10;
  localparam logic [ZONE_W-1:0]  SLOW_ZONE_RST   = 16'd700;

  localparam logic [CIDX_W-1:0] REG_SPEED_CAP   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SPEED_FLOOR = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SLOW_ZONE   = 2'd2;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [DIR_W-1:0] DIR_FWD     = 3'd0;
  localparam logic [DIR_W-1:0] DIR_BACK    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT    = 3'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT   = 3'd3;
  localparam logic [DIR_W-1:0] DIR_SPIN_R  = 3'd4;
  localparam logic [DIR_W-1:0] DIR_SPIN_L  = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_HOLD  = 2'd2
  } phase_t;

  typedef logic signed [ENC_W:0] travel_t;

  function automatic logic [ENC_W-1:0] pick_enc(input logic [DIR_W-1:0] dir,
                                                input logic [ENC_W-1:0] a,
                                                input logic [ENC_W-1:0] b,
                                                input logic [ENC_W-1:0] c);
    logic [ENC_W-1:0] r;
    unique case (dir)
      DIR_FWD:             r = c;
      DIR_BACK, DIR_RIGHT: r = b;
      default:             r = a;
    endcase
    return r;
  endfunction

  // bit k set means drive k+1 runs negative
  function automatic logic [3:0] dir_neg(input logic [DIR_W-1:0] dir);
    logic [3:0] r;
    unique case (dir)
      DIR_FWD:    r = 4'b0011;
      DIR_BACK:   r = 4'b1100;
      DIR_LEFT:   r = 4'b0110;
      DIR_RIGHT:  r = 4'b1001;
      DIR_SPIN_R: r = 4'b1111;
      default:    r = 4'b0000;
    endcase
    return r;
  endfunction

  function automatic logic [DRIVE_W-1:0] drive_val(input logic neg,
                                                   input logic [SPEED_W-1:0] spd);
    logic [DRIVE_W-1:0] m;
    m = {{(DRIVE_W-SPEED_W){1'b0}}, spd};
    return neg ? (~m + 1'b1) : m;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/rmp_in_if.sv
// interface: input word channel of the move profiler
`default_nettype none
interface rmp_in_if import rmp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [DIR_W-1:0]         direction;
  logic [DIST_W-1:0]        distance;
  logic signed [ENC_W-1:0]  enc_a;
  logic signed [ENC_W-1:0]  enc_b;
  logic signed [ENC_W-1:0]  enc_c;

  modport source (output valid, kind, direction, distance, enc_a, enc_b, enc_c,
                  input ready);
  modport sink   (input valid, kind, direction, distance, enc_a, enc_b, enc_c,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/rmp_out_if.sv
// interface: result word channel of the move profiler
`default_nettype none
interface rmp_out_if import rmp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] drive_one;
  logic signed [DRIVE_W-1:0] drive_two;
  logic signed [DRIVE_W-1:0] drive_three;
  logic signed [DRIVE_W-1:0] drive_four;
  logic                      busy_res;
  logic                      done_res;

  modport source (output valid, drive_one, drive_two, drive_three, drive_four,
                  busy_res, done_res, input ready);
  modport sink   (input valid, drive_one, drive_two, drive_three, drive_four,
                  busy_res, done_res, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rmp_cfg_if.sv
// interface: register write channel of the move profiler
`default_nettype none
interface rmp_cfg_if import rmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rmp_travel.sv
// travel measurement: watched encoder minus start offset, magnitude for spins
`default_nettype none
module rmp_travel import rmp_pkg::*; (
  input  wire logic [DIR_W-1:0] dir,
  input  wire logic [ENC_W-1:0] enc_a,
  input  wire logic [ENC_W-1:0] enc_b,
  input  wire logic [ENC_W-1:0] enc_c,
  input  wire logic [ENC_W-1:0] offset,
  output travel_t               travel
);

  logic [ENC_W-1:0] diff;
  travel_t          sdiff;
  logic             spin;

  always_comb begin
    diff  = pick_enc(dir, enc_a, enc_b, enc_c) - offset;
    sdiff = travel_t'({diff[ENC_W-1], diff});
    spin  = (dir == DIR_SPIN_R) || (dir == DIR_SPIN_L);
    if (spin && sdiff[ENC_W]) begin
      travel = -sdiff;
    end else begin
      travel = sdiff;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ramped_move_profile_unit.sv
// top level: trapezoidal speed profiler for a four-wheel base
//
// in_ch carries one word per control event: a start word (kind 0) latches
// direction, distance and the watched encoder as offset; a tick word (kind 1)
// carries fresh encoder samples and advances the speed profile.
// out_ch returns exactly one word per input word: four signed drive values,
// busy and done. cfg_ch writes the speed ceiling, the speed floor and
// slow_zone; it is always ready. it must be written only while the block
// is idle; the block itself does not enforce this. the state update and
// the result are computed from the input word in the accept cycle and
// land in the result register. throughput is one word per cycle, limited
// by the single result register; a new word is taken while the held result
// is taken in the same cycle. when the receiver stalls, the result holds
// and in_ch.ready drops until the result is taken.
// synchronous reset restores the register defaults 55, 10 and 700, makes the
// profiler idle and empties the result register.
`default_nettype none
module ramped_move_profile_unit import rmp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rmp_in_if.sink    in_ch,
  rmp_out_if.source out_ch,
  rmp_cfg_if.sink   cfg_ch
);

  logic [SPEED_W-1:0] speed_cap_r;
  logic [SPEED_W-1:0] speed_floor_r;
  logic [ZONE_W-1:0]  slow_zone_r;

  phase_t             phase_r, phase_nxt;
  logic [ENC_W-1:0]   offset_r, offset_nxt;
  logic [RAMP_W-1:0]  ramp_r, ramp_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic [DIST_W-1:0]  len_r, len_nxt;
  logic [DIR_W-1:0]   dir_r, dir_nxt;

  logic               out_valid_r;
  logic [DRIVE_W-1:0] d1_r, d2_r, d3_r, d4_r;
  logic               busy_r, done_r;

  logic [SPEED_W-1:0] emit_speed;
  logic [DIR_W-1:0]   emit_dir;
  logic               busy_nxt, done_nxt;
  logic [3:0]         neg;

  travel_t            travel;
  logic signed [ENC_W+1:0] t_x, len_x, half_x, lim_x;
  logic [SPEED_W-1:0] hold_speed;
  logic               accel_go;
  logic               acc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  rmp_travel u_travel (
    .dir    (dir_r),
    .enc_a  (in_ch.enc_a),
    .enc_b  (in_ch.enc_b),
    .enc_c  (in_ch.enc_c),
    .offset (offset_r),
    .travel (travel)
  );

  always_comb begin
    t_x    = {travel[ENC_W], travel};
    len_x  = $signed({{(ENC_W+2-DIST_W){1'b0}}, len_r});
    half_x = $signed({{(ENC_W+3-DIST_W){1'b0}}, len_r[DIST_W-1:1]});
    lim_x  = len_x - $signed({{(ENC_W+2-ZONE_W){1'b0}}, slow_zone_r});
  end

  always_comb begin
    phase_nxt  = phase_r;
    offset_nxt = offset_r;
    ramp_nxt   = ramp_r;
    speed_nxt  = speed_r;
    len_nxt    = len_r;
    dir_nxt    = dir_r;
    emit_speed = '0;
    emit_dir   = dir_r;
    busy_nxt   = 1'b0;
    done_nxt   = 1'b0;
    hold_speed = ramp_r[RAMP_W-1:1];
    accel_go   = 1'b0;
    if (in_ch.kind == KIND_START) begin
      if (in_ch.direction <= DIR_SPIN_L) begin
        dir_nxt    = in_ch.direction;
        len_nxt    = in_ch.distance;
        offset_nxt = pick_enc(in_ch.direction, in_ch.enc_a, in_ch.enc_b, in_ch.enc_c);
        ramp_nxt   = '0;
        speed_nxt  = '0;
        phase_nxt  = PH_ACCEL;
        busy_nxt   = 1'b1;
      end else begin
        busy_nxt   = (phase_r == PH_ACCEL) || (phase_r == PH_HOLD);
      end
    end else if ((phase_r == PH_ACCEL) || (phase_r == PH_HOLD)) begin
      if (phase_r == PH_ACCEL) begin
        if (t_x < half_x) begin
          accel_go = 1'b1;
          if (ramp_r < {speed_cap_r, 1'b0}) begin
            ramp_nxt = ramp_r + 1'b1;
          end
          speed_nxt  = ramp_nxt[RAMP_W-1:1];
          emit_speed = speed_nxt;
          busy_nxt   = 1'b1;
        end else begin
          hold_speed = ramp_r[RAMP_W-1:1];
          phase_nxt  = PH_HOLD;
        end
      end else begin
        hold_speed = speed_r;
      end
      if (!accel_go) begin
        if (t_x < len_x) begin
          if ((hold_speed > speed_floor_r) && (t_x > lim_x)) begin
            speed_nxt = hold_speed - 1'b1;
          end else begin
            speed_nxt = hold_speed;
          end
          emit_speed = speed_nxt;
          busy_nxt   = 1'b1;
        end else begin
          phase_nxt = PH_IDLE;
          speed_nxt = '0;
          done_nxt  = 1'b1;
        end
      end
    end
    neg = dir_neg(emit_dir);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_cap_r   <= SPEED_CAP_RST;
      speed_floor_r <= SPEED_FLOOR_RST;
      slow_zone_r   <= SLOW_ZONE_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_SPEED_CAP:   speed_cap_r   <= cfg_ch.data[SPEED_W-1:0];
        REG_SPEED_FLOOR: speed_floor_r <= cfg_ch.data[SPEED_W-1:0];
        REG_SLOW_ZONE:   slow_zone_r   <= cfg_ch.data[ZONE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      offset_r <= '0;
      ramp_r   <= '0;
      speed_r  <= '0;
      len_r    <= '0;
      dir_r    <= '0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      offset_r <= offset_nxt;
      ramp_r   <= ramp_nxt;
      speed_r  <= speed_nxt;
      len_r    <= len_nxt;
      dir_r    <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      d1_r   <= drive_val(neg[0], emit_speed);
      d2_r   <= drive_val(neg[1], emit_speed);
      d3_r   <= drive_val(neg[2], emit_speed);
      d4_r   <= drive_val(neg[3], emit_speed);
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_one   = $signed(d1_r);
  assign out_ch.drive_two   = $signed(d2_r);
  assign out_ch.drive_three = $signed(d3_r);
  assign out_ch.drive_four  = $signed(d4_r);
  assign out_ch.busy_res    = busy_r;
  assign out_ch.done_res    = done_r;

endmodule
`default_nettype wire

>>> tb/rmp_profile_checker.sv
// checker: watches the move profiler channels, predicts each result word and compares
module rmp_profile_checker import rmp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rmp_in_if         in_mon,
  rmp_out_if        out_mon,
  rmp_cfg_if        cfg_mon,
  output int        error_count,
  output int        pending_words,
  output int        words_checked,
  output int        moves_finished
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] d1;
    logic signed [DRIVE_W-1:0] d2;
    logic signed [DRIVE_W-1:0] d3;
    logic signed [DRIVE_W-1:0] d4;
    logic                      busy;
    logic                      done;
  } drive_word_t;

  logic [SPEED_W-1:0] cap_speed;
  logic [SPEED_W-1:0] floor_speed;
  logic [ZONE_W-1:0]  brake_zone;

  logic [ENC_W-1:0]   origin;
  logic [RAMP_W-1:0]  ramp;
  logic [SPEED_W-1:0] speed;
  phase_t             ph;
  logic [DIST_W-1:0]  target;
  logic [DIR_W-1:0]   heading;

  drive_word_t drive_q[$];
  int errs = 0;
  int shown = 0;
  int checked = 0;
  int finished = 0;

  function automatic logic [ENC_W-1:0] watched_enc(input logic [DIR_W-1:0] d,
                                                   input logic [ENC_W-1:0] a,
                                                   input logic [ENC_W-1:0] b,
                                                   input logic [ENC_W-1:0] c);
    logic [ENC_W-1:0] v;
    case (d)
      DIR_FWD:             v = c;
      DIR_BACK, DIR_RIGHT: v = b;
      default:             v = a;
    endcase
    return v;
  endfunction

  function automatic drive_word_t make_word(input logic [DIR_W-1:0] d,
                                            input logic [SPEED_W-1:0] s,
                                            input logic busy,
                                            input logic done);
    drive_word_t w;
    logic [3:0] neg;
    logic signed [DRIVE_W-1:0] mag;
    // msb is drive one
    case (d)
      DIR_FWD:    neg = 4'b1100;
      DIR_BACK:   neg = 4'b0011;
      DIR_LEFT:   neg = 4'b0110;
      DIR_RIGHT:  neg = 4'b1001;
      DIR_SPIN_R: neg = 4'b1111;
      default:    neg = 4'b0000;
    endcase
    mag = {1'b0, s};
    w.d1 = neg[3] ? -mag : mag;
    w.d2 = neg[2] ? -mag : mag;
    w.d3 = neg[1] ? -mag : mag;
    w.d4 = neg[0] ? -mag : mag;
    w.busy = busy;
    w.done = done;
    return w;
  endfunction

  function automatic drive_word_t step_profile(input logic kind,
                                               input logic [DIR_W-1:0] d,
                                               input logic [DIST_W-1:0] len,
                                               input logic [ENC_W-1:0] a,
                                               input logic [ENC_W-1:0] b,
                                               input logic [ENC_W-1:0] c);
    logic signed [ENC_W-1:0] delta;
    longint travel;
    longint span;
    if (kind == KIND_START) begin
      if (d <= DIR_SPIN_L) begin
        heading = d;
        target  = len;
        origin  = watched_enc(d, a, b, c);
        ramp    = '0;
        speed   = '0;
        ph      = PH_ACCEL;
      end
      return make_word(DIR_FWD, '0, ph == PH_ACCEL || ph == PH_HOLD, 1'b0);
    end
    if (!(ph == PH_ACCEL || ph == PH_HOLD))
      return make_word(DIR_FWD, '0, 1'b0, 1'b0);
    delta = watched_enc(heading, a, b, c) - origin;
    travel = delta;
    if (heading >= DIR_SPIN_R && travel < 0) travel = -travel;
    span = target;
    if (ph == PH_ACCEL) begin
      if (travel < span / 2) begin
        if (ramp < {cap_speed, 1'b0}) ramp++;
        speed = ramp[RAMP_W-1:1];
        return make_word(heading, speed, 1'b1, 1'b0);
      end
      speed = ramp[RAMP_W-1:1];
      ph = PH_HOLD;
    end
    if (travel < span) begin
      if (speed > floor_speed && travel > span - longint'(brake_zone)) speed--;
      return make_word(heading, speed, 1'b1, 1'b0);
    end
    ph = PH_IDLE;
    speed = '0;
    return make_word(heading, '0, 1'b0, 1'b1);
  endfunction

  task automatic check_field(input string name, input logic signed [DRIVE_W:0] want,
                             input logic signed [DRIVE_W:0] got);
    if (want !== got) begin
      errs++;
      if (shown < 40)
        $display("[%0t] %s mismatch: expected %0d, got %0d", $time, name, want, got);
      shown++;
    end
  endtask

  always @(posedge clk) begin
    drive_word_t want;
    if (!rst_n) begin
      cap_speed   = SPEED_CAP_RST;
      floor_speed = SPEED_FLOOR_RST;
      brake_zone  = SLOW_ZONE_RST;
      origin      = '0;
      ramp        = '0;
      speed       = '0;
      ph          = PH_IDLE;
      target      = '0;
      heading     = DIR_FWD;
      drive_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_SPEED_CAP:   cap_speed   = cfg_mon.data[SPEED_W-1:0];
          REG_SPEED_FLOOR: floor_speed = cfg_mon.data[SPEED_W-1:0];
          REG_SLOW_ZONE:   brake_zone  = cfg_mon.data[ZONE_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (drive_q.size() == 0) begin
          errs++;
          $display("[%0t] result word with nothing expected: drives %0d %0d %0d %0d",
                   $time, out_mon.drive_one, out_mon.drive_two, out_mon.drive_three,
                   out_mon.drive_four);
        end else begin
          want = drive_q.pop_front();
          checked++;
          check_field("drive_one", want.d1, out_mon.drive_one);
          check_field("drive_two", want.d2, out_mon.drive_two);
          check_field("drive_three", want.d3, out_mon.drive_three);
          check_field("drive_four", want.d4, out_mon.drive_four);
          check_field("busy_res", want.busy, out_mon.busy_res);
          check_field("done_res", want.done, out_mon.done_res);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = step_profile(in_mon.kind, in_mon.direction, in_mon.distance,
                            in_mon.enc_a, in_mon.enc_b, in_mon.enc_c);
        if (want.done) finished++;
        drive_q.push_back(want);
      end
    end
    error_count    <= errs;
    pending_words  <= drive_q.size();
    words_checked  <= checked;
    moves_finished <= finished;
  end

endmodule

>>> tb/tb_ramped_move_profile_unit.sv
// testbench top: clock, reset, stimulus and verdict for the move profiler
module tb_ramped_move_profile_unit import rmp_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst_n;

  rmp_in_if  in_ch();
  rmp_out_if out_ch();
  rmp_cfg_if cfg_ch();

  int bad;
  int pend;
  int checked;
  int finished;
  int counted_words = 0;
  int settings_run = 1;
  int quiet = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  ramped_move_profile_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  rmp_profile_checker prof_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_mon        (cfg_ch),
    .error_count    (bad),
    .pending_words  (pend),
    .words_checked  (checked),
    .moves_finished (finished)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(input logic kind, input logic [DIR_W-1:0] d,
                      input logic [DIST_W-1:0] len, input logic [ENC_W-1:0] a,
                      input logic [ENC_W-1:0] b, input logic [ENC_W-1:0] c);
    int gap;
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.direction <= d;
    in_ch.distance  <= len;
    in_ch.enc_a     <= a;
    in_ch.enc_b     <= b;
    in_ch.enc_c     <= c;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
  endtask

  // the encoder the direction watches gets v, the others are noise
  task automatic send_move_word(input logic kind, input logic [DIR_W-1:0] d,
                                input logic [DIST_W-1:0] len, input logic [ENC_W-1:0] v);
    logic [ENC_W-1:0] a;
    logic [ENC_W-1:0] b;
    logic [ENC_W-1:0] c;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    case (d)
      DIR_FWD:             c = v;
      DIR_BACK, DIR_RIGHT: b = v;
      default:             a = v;
    endcase
    send(kind, d, len, a, b, c);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pend != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CDAT_W-1:0] top_speed,
                            input logic [CDAT_W-1:0] low_speed,
                            input logic [CDAT_W-1:0] zone);
    logic [CDAT_W-1:0] vals[3];
    logic [CIDX_W-1:0] regs[3];
    int i;
    vals = '{top_speed, low_speed, zone};
    regs = '{REG_SPEED_CAP, REG_SPEED_FLOOR, REG_SLOW_ZONE};
    for (i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i];
      @(posedge clk);
      while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    settings_run++;
  endtask

  task automatic random_moves(input int n);
    int got;
    int r;
    int ticks;
    int step_hi;
    longint pos;
    logic [ENC_W-1:0] base;
    logic [DIR_W-1:0] d;
    logic [DIST_W-1:0] len;
    logic kind;
    bit spin_neg;
    got = 0;
    while (got < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        kind = 1'($urandom_range(0, 1));
        d = DIR_W'($urandom_range(0, 7));
        send(kind, d, DIST_W'($urandom), $urandom, $urandom, $urandom);
        if (kind == KIND_START && d <= DIR_SPIN_L) got++;
      end else begin
        d = DIR_W'($urandom_range(0, 5));
        r = $urandom_range(0, 99);
        if (r < 60) len = DIST_W'($urandom_range(0, 300));
        else if (r < 85) len = DIST_W'($urandom_range(0, 3000));
        else len = DIST_W'($urandom);
        r = $urandom_range(0, 9);
        if (r == 0) base = 32'h7FFF_FF00 + $urandom_range(0, 255);
        else if (r == 1) base = 32'hFFFF_FF00 + $urandom_range(0, 255);
        else base = $urandom;
        spin_neg = $urandom_range(0, 1);
        r = $urandom_range(0, 99);
        if (r < 25) step_hi = 2;
        else if (r < 85) step_hi = len / 16 + 1;
        else step_hi = len / 3 + 1;
        send_move_word(KIND_START, d, DIST_W'($urandom), base);
        got++;
        pos = 0;
        ticks = 0;
        while (ticks < 300) begin
          r = $urandom_range(0, 99);
          if (r < 2) break;
          if (r < 4) begin
            send(KIND_START, DIR_W'($urandom_range(6, 7)), DIST_W'($urandom),
                 $urandom, $urandom, $urandom);
          end else begin
            if (r < 9) pos -= $urandom_range(0, step_hi);
            else pos += $urandom_range(0, step_hi);
            send_move_word(KIND_TICK, d, DIST_W'($urandom),
                           (d >= DIR_SPIN_R && spin_neg) ? base - pos[31:0]
                                                         : base + pos[31:0]);
            got++;
            ticks++;
            if (pos >= len) break;
          end
        end
        if ($urandom_range(0, 9) == 0)
          send(KIND_TICK, DIR_W'($urandom_range(0, 7)), DIST_W'($urandom),
               $urandom, $urandom, $urandom);
      end
    end
    counted_words += got;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = steady ? 0 : idle_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("** ramped_move_profile_unit: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_START;
    in_ch.direction <= DIR_FWD;
    in_ch.distance  <= '0;
    in_ch.enc_a     <= '0;
    in_ch.enc_b     <= '0;
    in_ch.enc_c     <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= REG_SPEED_CAP;
    cfg_ch.data     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed words under the reset register values
    send(KIND_TICK, DIR_FWD, '0, '0, '0, '0);
    send(KIND_START, 3'd7, '1, '1, '1, '1);
    send_move_word(KIND_START, DIR_FWD, 16'd0, 32'h1234_5678);
    send_move_word(KIND_TICK, DIR_FWD, 16'd0, 32'h1234_5678);
    send_move_word(KIND_START, DIR_SPIN_R, 16'hFFFF, 32'h7FFF_FFFF);
    send_move_word(KIND_TICK, DIR_SPIN_R, 16'hFFFF, 32'hFFFF_FFFF);
    send(KIND_START, 3'd6, 16'd50, $urandom, $urandom, $urandom);
    send_move_word(KIND_START, DIR_BACK, 16'd10, 32'd100);
    send_move_word(KIND_TICK, DIR_BACK, 16'd0, 32'd95);
    send_move_word(KIND_TICK, DIR_BACK, 16'd0, 32'd105);
    send_move_word(KIND_TICK, DIR_BACK, 16'd0, 32'd110);
    send_move_word(KIND_START, DIR_LEFT, 16'd400, 32'h8000_0000);
    send_move_word(KIND_TICK, DIR_LEFT, 16'd0, 32'h8000_0032);
    send_move_word(KIND_TICK, DIR_LEFT, 16'd0, 32'h8000_0078);
    send_move_word(KIND_START, DIR_RIGHT, 16'd300, 32'hFFFF_FF00);
    send_move_word(KIND_TICK, DIR_RIGHT, 16'd0, 32'hFFFF_FF80);
    send(KIND_START, 3'd7, 16'd9, $urandom, $urandom, $urandom);
    send_move_word(KIND_TICK, DIR_RIGHT, 16'd0, 32'h0000_0040);
    send_move_word(KIND_START, DIR_SPIN_L, 16'd1000, 32'd0);
    send_move_word(KIND_TICK, DIR_SPIN_L, 16'd0, -32'sd600);
    send_move_word(KIND_TICK, DIR_SPIN_L, 16'd0, -32'sd1000);
    send_move_word(KIND_START, DIR_FWD, 16'hFFFF, 32'h7FFF_FFF0);
    send_move_word(KIND_TICK, DIR_FWD, 16'd0, 32'h8000_7FF0);
    send_move_word(KIND_TICK, DIR_FWD, 16'd0, 32'h8000_FFF0);
    send(KIND_TICK, DIR_SPIN_L, '1, '1, '1, '1);

    hold_req = 1'b1;
    random_moves(250);

    settle();
    write_regs(16'd1, 16'd0, 16'd0);
    random_moves(200);

    settle();
    write_regs(16'd100, 16'd100, 16'hFFFF);
    random_moves(200);

    settle();
    write_regs(16'd100, 16'd0, 16'hFFFF);
    steady = 1'b1;
    random_moves(200);
    steady = 1'b0;

    settle();
    write_regs(16'd1, 16'd100, 16'd0);
    random_moves(150);

    settle();
    write_regs(16'd6, 16'd2, 16'd40);
    random_moves(250);

    settle();
    write_regs(16'd30, 16'd12, 16'd300);
    random_moves(250);

    settle();
    write_regs(CDAT_W'($urandom_range(1, 100)), CDAT_W'($urandom_range(0, 100)),
               CDAT_W'($urandom));
    random_moves(200);

    settle();
    repeat (5) @(posedge clk);
    $display("%0d result words checked across %0d register settings, %0d moves reached target",
             checked, settings_run, finished);
    $display("%0d random move words sent, with one %0d-cycle result hold-off",
             counted_words, HOLD_CYCLES);
    if (bad == 0 && pend == 0) begin
      $display("** ramped_move_profile_unit: PASSED **");
    end else begin
      $display("** ramped_move_profile_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> ramped_move_profile_unit.f
rtl/core/rmp_pkg.sv
rtl/core/rmp_in_if.sv
rtl/core/rmp_out_if.sv
rtl/core/rmp_cfg_if.sv
rtl/core/rmp_travel.sv
rtl/core/ramped_move_profile_unit.sv
tb/rmp_profile_checker.sv
tb/tb_ramped_move_profile_unit.sv
